// ----- hw/rtl/pds_pkg.sv -----
// ============================================================================
// PLL divider search package
// Candidate divider tables, field widths and shared constants.
// ============================================================================
package pds_pkg;

    // Number of divider combinations tried for every target
    localparam int NUM_CAND = 44;

    // Per-stage widths of the candidate datapath
    localparam int TARGET_W = 20;
    localparam int FB_W     = 12;
    localparam int N_W      = 28;   // rounding numerator for the feedback divider
    localparam int Q_W      = 18;   // unbounded feedback divider
    localparam int Y_W      = 29;   // reference times feedback divider
    localparam int A_W      = 29;   // integer part of Y over D
    localparam int B_W      = 8;    // remainder before correction
    localparam int BC_W     = 7;    // remainder after correction
    localparam int M_W      = 16;   // numerator of the fraction step
    localparam int C_W      = 9;    // fraction step result
    localparam int ACT_W    = 38;   // actual frequency in Q.8 before saturation
    localparam int VCO_W    = 37;   // VCO frequency in Q.8
    localparam int PROD_W   = 6;    // post divider product
    localparam int ACT_OUT_W = 28;

    // Shift amounts of the reciprocal divisions
    localparam int SHIFT_FB  = 28;
    localparam int SHIFT_DIV = 29;
    localparam int SHIFT_FRC = 24;

    // Register indexes of the configuration port
    localparam logic CFG_FEEDBACK_MIN = 1'b0;
    localparam logic CFG_FEEDBACK_MAX = 1'b1;

    localparam logic [FB_W-1:0] FEEDBACK_MIN_RST = 12'd1;
    localparam logic [FB_W-1:0] FEEDBACK_MAX_RST = 12'd4095;

    // Result constants
    localparam logic [7:0] VCO_SCALE_HIGH = 8'h50;
    localparam logic [7:0] VCO_SCALE_LOW  = 8'h40;
    localparam logic [ACT_OUT_W-1:0] ACT_MAX = 28'hFFF_FFFF;
    localparam logic [ACT_W:0] TOL_Q8 = 39'd256;
    // 2400 MHz expressed in kHz Q.8
    localparam logic [VCO_W-1:0] VCO_SWITCH_Q8 = 37'd614400000;

    // Candidate order: reference 2 then 1, first post divider high to low,
    // second post divider high to low, first above second or both one.
    localparam logic [1:0] CAND_R [NUM_CAND] = '{
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

    localparam logic [2:0] CAND_P1 [NUM_CAND] = '{
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1,
        3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1
    };

    localparam logic [2:0] CAND_P2 [NUM_CAND] = '{
        3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
        3'd4, 3'd3, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1,
        3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1,
        3'd4, 3'd3, 3'd2, 3'd1, 3'd3, 3'd2, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1
    };

    // Running best candidate carried along the compare chain
    typedef struct packed {
        logic              have;
        logic [ACT_W-1:0]  diff;
        logic [VCO_W-1:0]  vco;
        logic [PROD_W-1:0] prod;
        logic [FB_W-1:0]   fb;
        logic [ACT_W-1:0]  act;
        logic [1:0]        rdiv;
        logic [2:0]        p1;
        logic [2:0]        p2;
    } best_t;

endpackage

// ----- hw/rtl/pll_divider_search_top.sv -----
// An accepted request passes through its candidate lanes and the compare chain into the output register.
// Throughput: one request per cycle while the skid entry is empty; each candidate has its own 8-stage lane and
// the 44 candidates are compared in order, one per pipeline stage.
// A two-entry output (register plus skid) lets requests enter while a result waits.
// Reset (aresetn low, synchronous) empties the pipeline and sets the feedback
// bounds to 1 and 4095.
// ============================================================================
// PLL divider search top level
// Deeply pipelined exhaustive search over reference and post divider pairs.
// ============================================================================
module pll_divider_search_top #(
    parameter int REF_KHZ = 25000
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] target_khz, [23:20] zero
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [11:0] feedback_div, [13:12] reference_div,
                                   // [16:14] first_post_div, [19:17] second_post_div,
                                   // [47:20] actual_khz_q8, [55:48] postdiv_byte,
                                   // [63:56] vco_scale_byte
    output logic [0:0]  m_tuser    // [0] found
);

    localparam int NC        = pds_pkg::NUM_CAND;
    localparam int LANE_D    = 8;
    localparam int PIPE_LAST = NC + LANE_D;
    localparam int TGT_LAST  = PIPE_LAST - 2;
    localparam longint DIV_FB = 2 * longint'(REF_KHZ);
    localparam longint MUL_FB = (longint'(1) << pds_pkg::SHIFT_FB) / DIV_FB;

    // Configuration registers
    logic [pds_pkg::FB_W-1:0] fb_min_reg;
    logic [pds_pkg::FB_W-1:0] fb_max_reg;

    // Main pipeline: valid bits and target carried along
    logic                         adv;
    logic [PIPE_LAST:0]           valid_reg;
    logic [pds_pkg::TARGET_W-1:0] target_reg [TGT_LAST+1];
    pds_pkg::best_t               best_reg   [NC];
    pds_pkg::best_t               best_next  [NC];

    // Output register and skid entry
    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_found_reg;
    logic        skid_valid_reg;
    logic [63:0] skid_data_reg;
    logic        skid_found_reg;
    logic [63:0] res_data_next;
    logic        res_found_next;

    // The whole pipeline moves unless the skid entry is occupied.
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_min_reg <= pds_pkg::FEEDBACK_MIN_RST;
            fb_max_reg <= pds_pkg::FEEDBACK_MAX_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pds_pkg::CFG_FEEDBACK_MIN: fb_min_reg <= cfg_wdata;
                pds_pkg::CFG_FEEDBACK_MAX: fb_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Valid bits of the main pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_LAST-1:0], s_tvalid};
        end
    end

    // Target shift line and compare chain registers.
    always_ff @(posedge aclk) begin
        if (adv) begin
            target_reg[0] <= s_tdata[pds_pkg::TARGET_W-1:0];
            for (int s = 1; s <= TGT_LAST; s++) begin
                target_reg[s] <= target_reg[s-1];
            end
            for (int c = 0; c < NC; c++) begin
                best_reg[c] <= best_next[c];
            end
        end
    end

    // One lane per candidate; lane k starts at main stage k and its result
    // meets the running best at stage k + 8.
    for (genvar k = 0; k < NC; k++) begin : g_lane
        localparam int R    = int'(pds_pkg::CAND_R[k]);
        localparam int P1   = int'(pds_pkg::CAND_P1[k]);
        localparam int P2   = int'(pds_pkg::CAND_P2[k]);
        localparam int PROD = P1 * P2;
        localparam int D    = R * PROD;
        localparam longint MUL_D  = (longint'(1) << pds_pkg::SHIFT_DIV) / D;
        localparam longint MUL_FR = ((longint'(1) << pds_pkg::SHIFT_FRC) + 2 * D - 1)
                                    / (2 * D);

        logic [pds_pkg::N_W-1:0]   n1_reg, n1_next, n2_reg;
        logic [pds_pkg::Q_W-1:0]   q2_reg, q2_next, fb3_reg, fb3_next;
        logic                      ok4_reg, ok4_next, ok5_reg, ok6_reg, ok7_reg, ok8_reg;
        logic [pds_pkg::FB_W-1:0]  fb4_reg, fb5_reg, fb6_reg, fb7_reg, fb8_reg;
        logic [pds_pkg::Y_W-1:0]   y4_reg, y4_next, y5_reg, y6_reg, y7_reg;
        logic [pds_pkg::A_W-1:0]   a5_reg, a5_next, a6_reg, a6_next, a7_reg;
        logic [pds_pkg::BC_W-1:0]  b6_reg, b6_next;
        logic [pds_pkg::C_W-1:0]   c7_reg, c7_next;
        logic [pds_pkg::ACT_W-1:0] act8_reg, act8_next, diff8_reg, diff8_next;
        logic [pds_pkg::VCO_W-1:0] vco8_reg, vco8_next;
        logic [pds_pkg::N_W-1:0]   qmul, rem;
        logic [pds_pkg::Y_W-1:0]   amul;
        logic [pds_pkg::B_W-1:0]   braw;
        logic [pds_pkg::M_W-1:0]   frac_num;
        logic [pds_pkg::ACT_W-1:0] t256;
        logic [pds_pkg::ACT_W:0]   d_ext, bd_ext, v_ext, bv_ext;
        logic                      better;
        pds_pkg::best_t            prev, cand;

        // Lane datapath.
        always_comb begin
            // Rounding numerator 2*target*D + REF
            n1_next = pds_pkg::N_W'(target_reg[k]) * pds_pkg::N_W'(2 * D)
                    + pds_pkg::N_W'(REF_KHZ);
            // Reciprocal estimate of n / (2*REF), low by at most one
            q2_next = pds_pkg::Q_W'((64'(n1_reg) * 64'(MUL_FB)) >> pds_pkg::SHIFT_FB);
            // Correction step
            qmul = pds_pkg::N_W'(q2_reg) * pds_pkg::N_W'(DIV_FB);
            rem  = n2_reg - qmul;
            fb3_next = (rem >= pds_pkg::N_W'(DIV_FB)) ? q2_reg + 1'b1 : q2_reg;
            // Bounds check and REF * feedback divider
            ok4_next = (fb3_reg >= pds_pkg::Q_W'(fb_min_reg)) &&
                       (fb3_reg <= pds_pkg::Q_W'(fb_max_reg));
            y4_next  = pds_pkg::Y_W'(REF_KHZ) * pds_pkg::Y_W'(fb3_reg[pds_pkg::FB_W-1:0]);
            // Quotient estimate of Y / D
            a5_next = pds_pkg::A_W'((64'(y4_reg) * 64'(MUL_D)) >> pds_pkg::SHIFT_DIV);
            // Remainder and correction
            amul = pds_pkg::Y_W'(a5_reg) * pds_pkg::Y_W'(D);
            braw = pds_pkg::B_W'(y5_reg - amul);
            if (braw >= pds_pkg::B_W'(D)) begin
                a6_next = a5_reg + 1'b1;
                b6_next = pds_pkg::BC_W'(braw - pds_pkg::B_W'(D));
            end else begin
                a6_next = a5_reg;
                b6_next = pds_pkg::BC_W'(braw);
            end
            // Rounded fraction (512*b + D) / (2*D), exact by reciprocal
            frac_num = pds_pkg::M_W'({b6_reg, 9'd0}) + pds_pkg::M_W'(D);
            c7_next  = pds_pkg::C_W'((64'(frac_num) * 64'(MUL_FR)) >> pds_pkg::SHIFT_FRC);
            // Actual frequency, error and VCO in Q.8
            act8_next = pds_pkg::ACT_W'({a7_reg, 8'h00}) + pds_pkg::ACT_W'(c7_reg);
            t256      = pds_pkg::ACT_W'({target_reg[k+7], 8'h00});
            diff8_next = (act8_next >= t256) ? act8_next - t256 : t256 - act8_next;
            vco8_next  = pds_pkg::VCO_W'(y7_reg) << (9 - R);
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                n1_reg   <= n1_next;
                n2_reg   <= n1_reg;
                q2_reg   <= q2_next;
                fb3_reg  <= fb3_next;
                ok4_reg  <= ok4_next;
                fb4_reg  <= fb3_reg[pds_pkg::FB_W-1:0];
                y4_reg   <= y4_next;
                ok5_reg  <= ok4_reg;
                fb5_reg  <= fb4_reg;
                y5_reg   <= y4_reg;
                a5_reg   <= a5_next;
                ok6_reg  <= ok5_reg;
                fb6_reg  <= fb5_reg;
                y6_reg   <= y5_reg;
                a6_reg   <= a6_next;
                b6_reg   <= b6_next;
                ok7_reg  <= ok6_reg;
                fb7_reg  <= fb6_reg;
                y7_reg   <= y6_reg;
                a7_reg   <= a6_reg;
                c7_reg   <= c7_next;
                ok8_reg  <= ok7_reg;
                fb8_reg  <= fb7_reg;
                act8_reg <= act8_next;
                diff8_reg <= diff8_next;
                vco8_reg <= vco8_next;
            end
        end

        // Compare this candidate with the running best.
        always_comb begin
            if (k == 0) begin
                prev = '0;
            end else begin
                prev = best_reg[(k == 0) ? 0 : k - 1];
            end
            cand.have = 1'b1;
            cand.diff = diff8_reg;
            cand.vco  = vco8_reg;
            cand.prod = pds_pkg::PROD_W'(PROD);
            cand.fb   = fb8_reg;
            cand.act  = act8_reg;
            cand.rdiv = 2'(R);
            cand.p1   = 3'(P1);
            cand.p2   = 3'(P2);
            d_ext  = {1'b0, diff8_reg};
            bd_ext = {1'b0, prev.diff};
            v_ext  = (pds_pkg::ACT_W + 1)'(vco8_reg);
            bv_ext = (pds_pkg::ACT_W + 1)'(prev.vco);
            better = 1'b0;
            if (ok8_reg) begin
                if (!prev.have) begin
                    better = 1'b1;
                end else if (d_ext + pds_pkg::TOL_Q8 < bd_ext) begin
                    better = 1'b1;
                end else if ((d_ext <= bd_ext + pds_pkg::TOL_Q8) &&
                             (bd_ext <= d_ext + pds_pkg::TOL_Q8)) begin
                    if (v_ext + pds_pkg::TOL_Q8 < bv_ext) begin
                        better = 1'b1;
                    end else if ((v_ext <= bv_ext + pds_pkg::TOL_Q8) &&
                                 (bv_ext <= v_ext + pds_pkg::TOL_Q8) &&
                                 (cand.prod < prev.prod)) begin
                        better = 1'b1;
                    end
                end
            end
        end

        assign best_next[k] = better ? cand : prev;
    end

    // Result formatting from the end of the compare chain.
    always_comb begin
        res_data_next  = '0;
        res_found_next = best_reg[NC-1].have;
        if (best_reg[NC-1].have) begin
            res_data_next[11:0]  = best_reg[NC-1].fb;
            res_data_next[13:12] = best_reg[NC-1].rdiv;
            res_data_next[16:14] = best_reg[NC-1].p1;
            res_data_next[19:17] = best_reg[NC-1].p2;
            if (best_reg[NC-1].act > pds_pkg::ACT_W'(pds_pkg::ACT_MAX)) begin
                res_data_next[47:20] = pds_pkg::ACT_MAX;
            end else begin
                res_data_next[47:20] = best_reg[NC-1].act[pds_pkg::ACT_OUT_W-1:0];
            end
            res_data_next[55:48] = {1'b0, best_reg[NC-1].p1 - 3'd1,
                                    1'b0, best_reg[NC-1].p2 - 3'd1};
            res_data_next[63:56] = (best_reg[NC-1].vco >= pds_pkg::VCO_SWITCH_Q8) ?
                                   pds_pkg::VCO_SCALE_HIGH : pds_pkg::VCO_SCALE_LOW;
        end
    end

    // Output register with skid entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= valid_reg[PIPE_LAST];
        end else if (valid_reg[PIPE_LAST]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg  <= skid_data_reg;
                m_found_reg <= skid_found_reg;
            end
        end else if (!m_valid_reg || m_tready) begin
            m_data_reg  <= res_data_next;
            m_found_reg <= res_found_next;
        end else begin
            skid_data_reg  <= res_data_next;
            skid_found_reg <= res_found_next;
        end
    end

`ifndef SYNTH
    // The skid entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry holds a result while the output register is empty");

    // A result without a match carries all-zero fields.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 64'd0))
        else $error("result without a match has nonzero fields");

    // A match always names a reference divider of one or two.
    a_found_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[13:12] == 2'd1 || m_tdata[13:12] == 2'd2))
        else $error("match without a valid reference divider");

    // A stalled skid entry stays until the output drains.
    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("skid entry lost while the output was stalled");
`endif

endmodule
